>>> hw/rtl/gbs_pkg.sv
// Shared types, constants and helpers for the gravity body step block.
// Used by gbs_front, gbs_back and gravity_body_step_top; depends on nothing.
`default_nettype none
package gbs_pkg;

	localparam int IN_DATA_W  = 168;
	localparam int OUT_DATA_W = 128;
	localparam int QUEUE_DEPTH = 2;
	localparam logic [31:0] GRAV_RESET = 32'h0001_0000;

	// Class of a queued item, decided by the front part.
	typedef enum logic [1:0] {
		KIND_LOAD,
		KIND_ATTRACT,
		KIND_PASS
	} kind_t;

	// One queued item as the back part sees it.
	typedef struct packed {
		kind_t       kind;
		logic [31:0] pos_x;
		logic [31:0] pos_y;
		logic [31:0] vel_x;
		logic [31:0] vel_y;
		logic [30:0] body_mass;
		logic        last;
	} entry_t;

	// Back part sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIFF,
		ST_SQX,
		ST_SQY,
		ST_KM,
		ST_ROOT,
		ST_FSET,
		ST_DIV,
		ST_MULX,
		ST_MULY,
		ST_ACC,
		ST_END
	} state_t;

	// Which quotient the shared divider is working on.
	typedef enum logic [1:0] {
		DIV_F,
		DIV_X,
		DIV_Y
	} div_sel_t;

	// Status of the back part seen by the top level.
	typedef struct packed {
		logic pop;
		logic emit;
	} bk_stat_t;

	// Saturate a 34-bit signed value to 32 bits.
	function automatic logic [31:0] sat32(input logic [33:0] v);
		logic [31:0] r;
		if (!v[33] && (v[32] || v[31])) begin
			r = 32'h7FFF_FFFF;
		end else if (v[33] && !(v[32] && v[31])) begin
			r = 32'h8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

>>> hw/rtl/gbs_front.sv
// Front part: accepts input items, classifies them and queues them.
// Depends on gbs_pkg.
`default_nettype none
module gbs_front (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           s_axis_tvalid,
	output logic                          s_axis_tready,
	input  wire  [gbs_pkg::IN_DATA_W-1:0] s_axis_tdata,
	input  wire                           s_axis_tuser,
	input  wire                           s_axis_tlast,
	output logic                          q_valid,
	output gbs_pkg::entry_t               q_entry,
	input  wire                           q_pop
);
	import gbs_pkg::*;

	entry_t      mem_q [QUEUE_DEPTH];
	logic        wptr_q;
	logic        rptr_q;
	logic [1:0]  count_q;
	logic [7:0]  id_q;
	logic        push;
	logic [7:0]  in_id;
	entry_t      in_entry;

	assign s_axis_tready = (count_q != 2'(QUEUE_DEPTH));
	assign push          = s_axis_tvalid && s_axis_tready;
	assign q_valid       = (count_q != 2'd0);
	assign q_entry       = mem_q[rptr_q];
	assign in_id         = s_axis_tdata[7:0];

	// Classify: loads, attractions and items from the target itself.
	always_comb begin
		in_entry.pos_x     = s_axis_tdata[39:8];
		in_entry.pos_y     = s_axis_tdata[71:40];
		in_entry.vel_x     = s_axis_tdata[103:72];
		in_entry.vel_y     = s_axis_tdata[135:104];
		in_entry.body_mass = s_axis_tdata[166:136];
		in_entry.last      = s_axis_tlast;
		if (!s_axis_tuser) begin
			in_entry.kind = KIND_LOAD;
		end else if (in_id == id_q) begin
			in_entry.kind = KIND_PASS;
		end else begin
			in_entry.kind = KIND_ATTRACT;
		end
	end

	// Queue pointers and the front copy of the target id.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= 2'd0;
			id_q    <= 8'd0;
		end else begin
			if (push) begin
				wptr_q <= ~wptr_q;
				if (!s_axis_tuser) begin
					id_q <= in_id;
				end
			end
			if (q_pop) begin
				rptr_q <= ~rptr_q;
			end
			if (push && !q_pop) begin
				count_q <= count_q + 2'd1;
			end else if (!push && q_pop) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= in_entry;
		end
	end

endmodule
`default_nettype wire

>>> hw/rtl/gbs_back.sv
// Back part: sequencer that applies attractions, finishes steps and
// holds the result register. Depends on gbs_pkg.
`default_nettype none
module gbs_back (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            cfg_we,
	input  wire  [31:0]                    cfg_wdata,
	input  wire                            q_valid,
	input  gbs_pkg::entry_t                q_entry,
	output gbs_pkg::bk_stat_t              stat,
	output logic                           m_axis_tvalid,
	input  wire                            m_axis_tready,
	output logic [gbs_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	output logic                           m_axis_tuser
);
	import gbs_pkg::*;

	state_t      state_q, state_d;
	div_sel_t    dsel_q;
	entry_t      cur_q;
	logic [31:0] grav_q;
	logic [31:0] tx_q, ty_q, vx_q, vy_q;
	logic        zds_q;
	logic [30:0] ax_q, ay_q;
	logic [1:0]  s_q;
	logic        sgx_q, sgy_q;
	logic [63:0] sum_q;
	logic [62:0] num_q;
	logic [63:0] rv_q, r_q, b_q;
	logic [4:0]  cnt_q;
	logic [63:0] rem_q, den_q;
	logic [31:0] low_q, quo_q;
	logic [31:0] f_q, cx_q, cy_q, mx_q, my_q;
	logic        out_vld_q;
	logic [127:0] out_data_q;
	logic        out_flag_q;

	logic [32:0] dx, dy, adx, ady;
	logic [1:0]  shamt;
	logic        dzero;
	logic [61:0] sq_x, sq_y;
	logic [63:0] root_t;
	logic        root_ge;
	logic [64:0] div_t;
	logic        div_ge;
	logic [31:0] quo_next;
	logic [66:0] sat_lim;
	logic        f_sat;
	logic [63:0] prod_x, prod_y;
	logic [33:0] vx_sum, vy_sum, px_sum, py_sum;
	logic        pop, emit;

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_flag_q;
	assign stat.pop      = pop;
	assign stat.emit     = emit;

	// Differences and magnitudes, scaled so both fit in 31 bits.
	always_comb begin
		dx    = {cur_q.pos_x[31], cur_q.pos_x} - {tx_q[31], tx_q};
		dy    = {cur_q.pos_y[31], cur_q.pos_y} - {ty_q[31], ty_q};
		adx   = dx[32] ? (33'd0 - dx) : dx;
		ady   = dy[32] ? (33'd0 - dy) : dy;
		dzero = (dx == 33'd0) && (dy == 33'd0);
		if (adx[32] || ady[32]) begin
			shamt = 2'd2;
		end else if (adx[31] || ady[31]) begin
			shamt = 2'd1;
		end else begin
			shamt = 2'd0;
		end
	end

	// Squares, one step of the square root, one step of the divider, the force saturation check, products and sums.
	always_comb begin
		sq_x     = ax_q * ax_q;
		sq_y     = ay_q * ay_q;
		root_t   = r_q + b_q;
		root_ge  = (rv_q >= root_t);
		div_t    = {rem_q, low_q[31]};
		div_ge   = (div_t >= {1'b0, den_q});
		quo_next = {quo_q[30:0], div_ge};
		sat_lim  = {3'd0, sum_q} << {s_q, 1'b0};
		f_sat    = ({4'd0, num_q} >= sat_lim);
		prod_x   = f_q * cx_q;
		prod_y   = f_q * cy_q;
		vx_sum   = {{2{vx_q[31]}}, vx_q} + (sgx_q ? (34'd0 - {2'd0, mx_q}) : {2'd0, mx_q});
		vy_sum   = {{2{vy_q[31]}}, vy_q} + (sgy_q ? (34'd0 - {2'd0, my_q}) : {2'd0, my_q});
		px_sum   = {{2{tx_q[31]}}, tx_q} + {{2{vx_q[31]}}, vx_q};
		py_sum   = {{2{ty_q[31]}}, ty_q} + {{2{vy_q[31]}}, vy_q};
	end

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state, queue pop and result hand-off.
	always_comb begin
		state_d = state_q;
		pop     = 1'b0;
		emit    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					pop = 1'b1;
					if (q_entry.kind == KIND_ATTRACT) begin
						state_d = ST_DIFF;
					end else begin
						state_d = ST_END;
					end
				end
			end
			ST_DIFF: state_d = dzero ? ST_END : ST_SQX;
			ST_SQX:  state_d = ST_SQY;
			ST_SQY:  state_d = ST_KM;
			ST_KM:   state_d = (sum_q == 64'd0) ? ST_END : ST_ROOT;
			ST_ROOT: begin
				if (cnt_q == 5'd0) begin
					state_d = ST_FSET;
				end
			end
			ST_FSET: state_d = ST_DIV;
			ST_DIV: begin
				if (cnt_q == 5'd0 && dsel_q == DIV_Y) begin
					state_d = ST_MULX;
				end
			end
			ST_MULX: state_d = ST_MULY;
			ST_MULY: state_d = ST_ACC;
			ST_ACC:  state_d = ST_END;
			ST_END: begin
				if (!cur_q.last) begin
					state_d = ST_IDLE;
				end else if (!out_vld_q || m_axis_tready) begin
					emit    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Target state, constant register and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grav_q    <= GRAV_RESET;
			tx_q      <= 32'd0;
			ty_q      <= 32'd0;
			vx_q      <= 32'd0;
			vy_q      <= 32'd0;
			zds_q     <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				grav_q <= cfg_wdata;
			end
			if (emit) begin
				out_vld_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (q_valid && q_entry.kind == KIND_LOAD) begin
						tx_q  <= q_entry.pos_x;
						ty_q  <= q_entry.pos_y;
						vx_q  <= q_entry.vel_x;
						vy_q  <= q_entry.vel_y;
						zds_q <= 1'b0;
					end
				end
				ST_DIFF: begin
					if (dzero) begin
						zds_q <= 1'b1;
					end
				end
				ST_KM: begin
					if (sum_q == 64'd0) begin
						zds_q <= 1'b1;
					end
				end
				ST_ACC: begin
					vx_q <= sat32(vx_sum);
					vy_q <= sat32(vy_sum);
				end
				ST_END: begin
					if (emit) begin
						tx_q  <= sat32(px_sum);
						ty_q  <= sat32(py_sum);
						zds_q <= 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Arithmetic datapath of one attraction and the result payload.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					cur_q <= q_entry;
				end
			end
			ST_DIFF: begin
				ax_q  <= 31'(adx >> shamt);
				ay_q  <= 31'(ady >> shamt);
				s_q   <= shamt;
				sgx_q <= dx[32];
				sgy_q <= dy[32];
			end
			ST_SQX: sum_q <= {2'd0, sq_x};
			ST_SQY: sum_q <= sum_q + {2'd0, sq_y};
			ST_KM: begin
				num_q <= grav_q * cur_q.body_mass;
				rv_q  <= sum_q;
				r_q   <= 64'd0;
				b_q   <= 64'd1 << 62;
				cnt_q <= 5'd31;
			end
			ST_ROOT: begin
				if (root_ge) begin
					rv_q <= rv_q - root_t;
					r_q  <= (r_q >> 1) + b_q;
				end else begin
					r_q <= r_q >> 1;
				end
				b_q   <= b_q >> 2;
				cnt_q <= cnt_q - 5'd1;
			end
			ST_FSET: begin
				cnt_q <= 5'd31;
				quo_q <= 32'd0;
				if (f_sat) begin
					f_q    <= 32'hFFFF_FFFF;
					dsel_q <= DIV_X;
					rem_q  <= {35'd0, ax_q[30:2]};
					low_q  <= {ax_q[1:0], 30'd0};
					den_q  <= {32'd0, r_q[31:0]};
				end else begin
					dsel_q <= DIV_F;
					den_q  <= sum_q;
					case (s_q)
						2'd1: begin
							rem_q <= {3'd0, num_q[62:2]};
							low_q <= {num_q[1:0], 30'd0};
						end
						2'd2: begin
							rem_q <= {5'd0, num_q[62:4]};
							low_q <= {num_q[3:0], 28'd0};
						end
						default: begin
							rem_q <= {1'b0, num_q};
							low_q <= 32'd0;
						end
					endcase
				end
			end
			ST_DIV: begin
				if (div_ge) begin
					rem_q <= 64'(div_t - {1'b0, den_q});
				end else begin
					rem_q <= div_t[63:0];
				end
				low_q <= {low_q[30:0], 1'b0};
				quo_q <= quo_next;
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd0) begin
					quo_q <= 32'd0;
					cnt_q <= 5'd31;
					den_q <= {32'd0, r_q[31:0]};
					case (dsel_q)
						DIV_F: begin
							f_q    <= quo_next;
							dsel_q <= DIV_X;
							rem_q  <= {35'd0, ax_q[30:2]};
							low_q  <= {ax_q[1:0], 30'd0};
						end
						DIV_X: begin
							cx_q   <= quo_next;
							dsel_q <= DIV_Y;
							rem_q  <= {35'd0, ay_q[30:2]};
							low_q  <= {ay_q[1:0], 30'd0};
						end
						default: begin
							cy_q <= quo_next;
						end
					endcase
				end
			end
			ST_MULX: mx_q <= prod_x[61:30];
			ST_MULY: my_q <= prod_y[61:30];
			ST_END: begin
				if (emit) begin
					out_data_q <= {vy_q, vx_q, sat32(py_sum), sat32(px_sum)};
					out_flag_q <= zds_q;
				end
			end
			default: begin
			end
		endcase
	end

endmodule
`default_nettype wire

>>> hw/rtl/gravity_body_step_top.sv
// Top level of the gravity body step block: front queue plus back sequencer.
// Depends on gbs_pkg, gbs_front and gbs_back.
//
//  channel   | signals                          | item
//  s_axis    | tvalid tready tdata tuser tlast  | load or attract request
//  m_axis    | tvalid tready tdata tuser        | new body state after last
//  cfg       | cfg_we cfg_wdata                 | gravitational constant
//
// A load or same-id item passes the back part's idle and end states, a body at
// zero distance also the difference state; an attraction runs the 32-step
// square root and the three 32-step divisions one after another (the force
// division is skipped when the force saturates). Reset clears the target state to
// zero and the constant to 1.0. The front queue holds two items, so input is
// taken while the back part works or the result register waits on m_axis_tready.
`default_nettype none
module gravity_body_step_top (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            cfg_we,
	input  wire  [31:0]                    cfg_wdata,
	input  wire                            s_axis_tvalid,
	output logic                           s_axis_tready,
	// body_id, pos_x, pos_y, vel_x, vel_y, body_mass, zero pad
	input  wire  [gbs_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	// req_type
	input  wire                            s_axis_tuser,
	input  wire                            s_axis_tlast,
	output logic                           m_axis_tvalid,
	input  wire                            m_axis_tready,
	// new_x, new_y, new_vx, new_vy
	output logic [gbs_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	// coincident
	output logic                           m_axis_tuser
);
	import gbs_pkg::*;

	logic     q_valid;
	entry_t   q_entry;
	bk_stat_t stat;

	gbs_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.q_valid       (q_valid),
		.q_entry       (q_entry),
		.q_pop         (stat.pop)
	);

	gbs_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.q_valid       (q_valid),
		.q_entry       (q_entry),
		.stat          (stat),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

`ifndef SYNTHESIS
	// The back part never takes an item from an empty queue.
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		stat.pop |-> q_valid) else $error("pop from empty queue");

	// A result is never written over one that still waits.
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		stat.emit |-> (!m_axis_tvalid || m_axis_tready))
		else $error("result overwritten");

	// A result appears only after the back part emitted it.
	a_valid_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(stat.emit)) else $error("result from nowhere");
`endif

endmodule
`default_nettype wire
